### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vha_pkg.sv
package vha_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 16;
  localparam int GUARD_BITS    = 24;
  localparam int TAB_LEN       = 24;
  localparam int ANG_BITS      = 22;
  localparam int Z_BITS        = 25;
  localparam int HEAD_BITS     = 17;
  localparam int ROUND_SHIFT   = 9;

  localparam logic signed [Z_BITS-1:0]    ROUND_BIAS = 25'sd256;
  localparam logic signed [HEAD_BITS-1:0] DEG90      = 17'sd11520;
  localparam logic signed [HEAD_BITS-1:0] DEG180     = 17'sd23040;
  localparam int HEAD_MIN = -34560;
  localparam int HEAD_MAX = 11520;

  // atan(2^-i) in units of 2^-16 degree
  localparam logic [ANG_BITS-1:0] ANGLE_TAB [TAB_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic degenerate;
    logic dx_zero;
    logic ady_zero;
    logic dx_neg;
    logic dy_pos;
  } flags_t;

endpackage

### src/vha_cordic_stage.sv
module vha_cordic_stage #(
  parameter int W     = vha_pkg::COORD_BITS + vha_pkg::GUARD_BITS + 3,
  parameter int SHIFT = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [W-1:0]                in_x,
  input  logic signed [W-1:0]                in_y,
  input  logic signed [vha_pkg::Z_BITS-1:0]  in_z,
  input  vha_pkg::flags_t                    in_flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [W-1:0]                out_x,
  output logic signed [W-1:0]                out_y,
  output logic signed [vha_pkg::Z_BITS-1:0]  out_z,
  output vha_pkg::flags_t                    out_flags
);

  logic signed [W-1:0]               xs;
  logic signed [W-1:0]               ys;
  logic signed [W-1:0]               x_next;
  logic signed [W-1:0]               y_next;
  logic signed [vha_pkg::Z_BITS-1:0] ang;
  logic signed [vha_pkg::Z_BITS-1:0] z_next;
  logic                              y_pos;

  assign xs    = in_x >>> SHIFT;
  assign ys    = in_y >>> SHIFT;
  assign ang   = signed'({{(vha_pkg::Z_BITS - vha_pkg::ANG_BITS){1'b0}},
                          vha_pkg::ANGLE_TAB[SHIFT]});
  assign y_pos = !in_y[W-1] && (in_y != '0);

  // rotate toward the x axis
  always_comb begin
    if (y_pos) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ang;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ang;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x     <= x_next;
      out_y     <= y_next;
      out_z     <= z_next;
      out_flags <= in_flags;
    end
  end

endmodule

### src/vector_heading_angle_core.sv
// heading angle of the vector between two points, pipelined cordic in vectoring mode
//
// input channel s_axis: one beat carries a start point and an end point, each
//   coordinate a signed q8.8 value of COORD_BITS bits
// output channel m_axis: one beat per input beat, in order; heading in 1/128 degree
//   (-270..90 degrees) in tdata, degenerate flag in tuser (points coincide, heading 0)
// pipeline, from accepted input beat to valid output beat: difference stage, setup
//   stage, one stage per cordic micro-rotation, rounding stage, output register
// throughput: one beat per cycle without back-pressure; every stage is a register
//   with its own valid bit, and each micro-rotation stage holds one level of wide adds
// stall: when m_axis_tready is low the output register holds its beat and the stages
//   behind it keep filling their empty slots, so s_axis_tready only drops once every
//   stage holds a beat; nothing is lost or repeated
// reset: synchronous, clears all valid bits; the pipeline is empty and ready at once
`include "assert_macros.svh"

module vector_heading_angle_core #(
  parameter int CORDIC_STAGES = vha_pkg::CORDIC_STAGES,
  parameter int COORD_BITS    = vha_pkg::COORD_BITS,
  localparam int InW          = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OutW         = ((vha_pkg::HEAD_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // from_x, from_y, to_x, to_y (COORD_BITS each), zero fill
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // heading (17 bits, signed), zero fill
  output logic [OutW-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]      m_axis_tuser
);

  localparam int DW = COORD_BITS + 1;                        // point difference
  localparam int W  = COORD_BITS + vha_pkg::GUARD_BITS + 3;  // cordic vector
  localparam int ZW = vha_pkg::Z_BITS;
  localparam int HW = vha_pkg::HEAD_BITS;

  // input fields
  logic signed [COORD_BITS-1:0] from_x, from_y, to_x, to_y;
  logic signed [DW-1:0]         dx_next, dy_next;

  assign from_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign from_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign to_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign to_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];

  assign dx_next = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
  assign dy_next = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};

  // stage a: point differences
  logic                 a_valid, a_ready;
  logic signed [DW-1:0] a_dx, a_dy;

  // stage b: cordic start vector and special-case flags
  logic                 b_valid, b_ready;
  logic signed [W-1:0]  b_x, b_y;
  vha_pkg::flags_t      b_flags;
  logic signed [DW-1:0] ady;
  logic signed [W-1:0]  b_x_next, b_y_next;
  vha_pkg::flags_t      b_flags_next;

  // cordic chain, index k is the input of micro-rotation k
  logic signed [W-1:0]  cx [CORDIC_STAGES+1];
  logic signed [W-1:0]  cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  vha_pkg::flags_t      cf [CORDIC_STAGES+1];
  logic                 cv [CORDIC_STAGES+1];
  logic                 cr [CORDIC_STAGES+1];

  // stage r: rounded, saturated base angle
  logic                 r_valid, r_ready;
  logic signed [HW-1:0] r_base;
  vha_pkg::flags_t      r_flags;
  logic signed [ZW-1:0] z_round, z_shift;
  logic signed [HW-1:0] base_next;

  // stage o: output register
  logic                 o_valid, o_ready;
  logic signed [HW-1:0] o_heading;
  logic                 o_degen;
  logic signed [HW-1:0] heading_next;

  assign s_axis_tready = a_ready;
  assign a_ready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_axis_tvalid) begin
      a_dx <= dx_next;
      a_dy <= dy_next;
    end
  end

  // |dy| never overflows: dy stays within +-(2^COORD_BITS - 1)
  assign ady      = a_dy[DW-1] ? -a_dy : a_dy;
  assign b_x_next = W'(ady) <<< vha_pkg::GUARD_BITS;
  assign b_y_next = W'(a_dx) <<< vha_pkg::GUARD_BITS;

  always_comb begin
    b_flags_next.dx_zero    = (a_dx == '0);
    b_flags_next.ady_zero   = (a_dy == '0);
    b_flags_next.degenerate = (a_dx == '0) && (a_dy == '0);
    b_flags_next.dx_neg     = a_dx[DW-1];
    b_flags_next.dy_pos     = !a_dy[DW-1] && (a_dy != '0);
  end

  assign b_ready = !b_valid || cr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_x     <= b_x_next;
      b_y     <= b_y_next;
      b_flags <= b_flags_next;
    end
  end

  assign cx[0] = b_x;
  assign cy[0] = b_y;
  assign cz[0] = '0;
  assign cf[0] = b_flags;
  assign cv[0] = b_valid;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    vha_cordic_stage #(
      .W     (W),
      .SHIFT (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_x      (cx[k]),
      .in_y      (cy[k]),
      .in_z      (cz[k]),
      .in_flags  (cf[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_x     (cx[k+1]),
      .out_y     (cy[k+1]),
      .out_z     (cz[k+1]),
      .out_flags (cf[k+1])
    );
  end

  assign cr[CORDIC_STAGES] = r_ready;

  // round the 2^-16 degree accumulator to 1/128 degree, saturate to +-90
  assign z_round = cz[CORDIC_STAGES] + vha_pkg::ROUND_BIAS;
  assign z_shift = z_round >>> vha_pkg::ROUND_SHIFT;

  always_comb begin
    if (cf[CORDIC_STAGES].dx_zero) begin
      base_next = '0;                      // vertical vector or coinciding points
    end else if (cf[CORDIC_STAGES].ady_zero) begin
      base_next = cf[CORDIC_STAGES].dx_neg ? -vha_pkg::DEG90 : vha_pkg::DEG90;
    end else if (z_shift > ZW'(vha_pkg::DEG90)) begin
      base_next = vha_pkg::DEG90;
    end else if (z_shift < -ZW'(vha_pkg::DEG90)) begin
      base_next = -vha_pkg::DEG90;
    end else begin
      base_next = z_shift[HW-1:0];
    end
  end

  assign r_ready = !r_valid || o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (r_ready) begin
      r_valid <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready && cv[CORDIC_STAGES]) begin
      r_base  <= base_next;
      r_flags <= cf[CORDIC_STAGES];
    end
  end

  // a vector pointing toward positive y folds into -270..-90
  assign heading_next = r_flags.dy_pos ? -(vha_pkg::DEG180 + r_base) : r_base;

  assign o_ready = !o_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && r_valid) begin
      o_heading <= heading_next;
      o_degen   <= r_flags.degenerate;
    end
  end

  assign m_axis_tvalid   = o_valid;
  assign m_axis_tdata    = {{(OutW - HW){1'b0}}, o_heading};
  assign m_axis_tuser[0] = o_degen;

  `ASSERT_IMPLIES(a_degen_zero, clk, rst, o_valid && o_degen, o_heading == '0, "degenerate beat with nonzero heading")
  `ASSERT_IMPLIES(a_head_range, clk, rst, o_valid, (int'(o_heading) >= vha_pkg::HEAD_MIN) && (int'(o_heading) <= vha_pkg::HEAD_MAX), "heading out of range")
  `ASSERT_IMPLIES(a_empty_ready, clk, rst, !o_valid, s_axis_tready, "input stalled with empty output register")
  `ASSERT_NEXT(a_degen_flag, clk, rst, a_valid && b_ready && (a_dx == '0) && (a_dy == '0), b_valid && b_flags.degenerate, "coinciding points not flagged")

endmodule

### test/heading_checker.sv
// watches both channels of the heading core, predicts every output beat and compares
module heading_checker #(
  localparam int InW  = ((4 * vha_pkg::COORD_BITS + 7) / 8) * 8,
  localparam int OutW = ((vha_pkg::HEAD_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tready,
  // from_x, from_y, to_x, to_y, zero fill
  input  logic [InW-1:0]  s_axis_tdata,
  input  logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // heading, zero fill
  input  logic [OutW-1:0] m_axis_tdata,
  // degenerate
  input  logic [0:0]      m_axis_tuser,
  output int              fail_count,
  output int              pending
);

  localparam int    CB         = vha_pkg::COORD_BITS;
  localparam int    HB         = vha_pkg::HEAD_BITS;
  localparam longint RIGHT_ANGLE = 11520;
  localparam longint HALF_TURN   = 23040;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic signed [HB-1:0] heading;
    logic                 degenerate;
  } heading_t;

  heading_t heading_q[$];

  // atan(2^-i) in 2^-16 degree
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // angle of (ady, dx) in 1/128 degree, -90..90
  function automatic longint cordic_angle(input longint dx, input longint ady);
    longint x, y, z, xs, ys, r;
    if (dx == 0) return 0;
    if (ady == 0) return (dx > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
    x = ady <<< vha_pkg::GUARD_BITS;
    y = dx <<< vha_pkg::GUARD_BITS;
    z = 0;
    for (int i = 0; i < vha_pkg::CORDIC_STAGES && i < vha_pkg::TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    r = (z + longint'(vha_pkg::ROUND_BIAS)) >>> vha_pkg::ROUND_SHIFT;
    if (r > RIGHT_ANGLE) r = RIGHT_ANGLE;
    if (r < -RIGHT_ANGLE) r = -RIGHT_ANGLE;
    return r;
  endfunction

  function automatic heading_t predict_heading(input logic [InW-1:0] beat);
    coord_t   fx, fy, tx, ty;
    longint   dx, dy, h;
    heading_t res;
    fx = beat[0 +: CB];
    fy = beat[CB +: CB];
    tx = beat[2*CB +: CB];
    ty = beat[3*CB +: CB];
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    if (dx == 0 && dy == 0) begin
      res.heading    = '0;
      res.degenerate = 1'b1;
      return res;
    end
    h = cordic_angle(dx, (dy < 0) ? -dy : dy);
    if (dy > 0) h = -(HALF_TURN + h);
    res.heading    = h[HB-1:0];
    res.degenerate = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    heading_t want, got;
    int       errs;
    errs = 0;
    if (rst) begin
      heading_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.heading    = m_axis_tdata[HB-1:0];
        got.degenerate = m_axis_tuser[0];
        if (heading_q.size() == 0) begin
          $error("output beat with nothing expected: heading %0d degenerate %0d",
                 got.heading, got.degenerate);
          errs++;
        end else begin
          want = heading_q.pop_front();
          if (got.heading !== want.heading) begin
            $error("heading mismatch: expected %0d, got %0d", want.heading, got.heading);
            errs++;
          end
          if (got.degenerate !== want.degenerate) begin
            $error("degenerate mismatch: expected %0d, got %0d",
                   want.degenerate, got.degenerate);
            errs++;
          end
          if (m_axis_tdata[OutW-1:HB] !== '0) begin
            $error("tdata fill mismatch: expected 0, got %0h", m_axis_tdata[OutW-1:HB]);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        heading_q.push_back(predict_heading(s_axis_tdata));
      fail_count <= fail_count + errs;
      pending    <= heading_q.size();
    end
  end

endmodule

### test/tb.sv
// stimulus for the heading core: directed corner pairs, then random point pairs in phases
// with random idling on both channels and one long output stall
module tb;

  localparam int InW  = ((4 * vha_pkg::COORD_BITS + 7) / 8) * 8;
  localparam int OutW = ((vha_pkg::HEAD_BITS + 7) / 8) * 8;
  localparam int LATENCY   = vha_pkg::CORDIC_STAGES + 4;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_LEN = 412;

  typedef logic signed [vha_pkg::COORD_BITS-1:0] coord_t;

  localparam coord_t C_MIN = coord_t'(-32768);
  localparam coord_t C_MAX = coord_t'(32767);

  logic            clk = 1'b0;
  logic            rst;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic [0:0]      m_axis_tuser;
  int              fail_count;
  int              pending;

  // quiet: no idling on either side; hold_off: receiver takes one long stall
  bit quiet    = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vector_heading_angle_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  heading_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // idle length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate moved by a small offset, held inside the signed range
  function automatic coord_t nudge(input coord_t c, input int d);
    longint v;
    v = longint'(c) + d;
    if (v > longint'(C_MAX)) v = C_MAX;
    if (v < longint'(C_MIN)) v = C_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return coord_t'(-32767);
      2:       return coord_t'(-1);
      3:       return coord_t'(0);
      4:       return coord_t'(1);
      default: return C_MAX;
    endcase
  endfunction

  // offer one beat, hold it until accepted, then maybe go idle
  task automatic send_pair(input coord_t fx, input coord_t fy, input coord_t tx,
                           input coord_t ty);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ty, tx, fy, fx};
    do @(posedge clk); while (!s_axis_tready);
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one random pair, weighted toward the interesting geometries
  task automatic send_random();
    coord_t fx, fy, tx, ty;
    int     r;
    r  = $urandom_range(0, 99);
    fx = coord_t'($urandom);
    fy = coord_t'($urandom);
    tx = coord_t'($urandom);
    ty = coord_t'($urandom);
    if (r < 45) begin
      // fully random, covers every bit both ways
    end else if (r < 65) begin
      // short vectors, where the rounding of small angles matters
      tx = nudge(fx, int'($urandom_range(0, 16)) - 8);
      ty = nudge(fy, int'($urandom_range(0, 16)) - 8);
    end else if (r < 72) begin
      tx = fx;
      ty = fy;
    end else if (r < 80) begin
      tx = fx;
    end else if (r < 88) begin
      ty = fy;
    end else begin
      fx = corner_coord();
      fy = corner_coord();
      tx = corner_coord();
      ty = corner_coord();
    end
    send_pair(fx, fy, tx, ty);
  endtask

  // receiver: bursts of ready with random stalls, plus one long hold when asked
  initial begin
    int g;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 32)) @(posedge clk);
      g = quiet ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // run limit, far above the slowest correct run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int waited;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // coinciding points, including the range ends
    send_pair(0, 0, 0, 0);
    send_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    // vertical vectors, up and down
    send_pair(0, 0, 0, 256);
    send_pair(0, 0, 0, -256);
    send_pair(C_MAX, C_MIN, C_MAX, C_MAX);
    send_pair(C_MIN, C_MAX, C_MIN, C_MIN);
    // horizontal vectors, right and left
    send_pair(0, 0, 256, 0);
    send_pair(0, 0, -256, 0);
    send_pair(C_MIN, C_MAX, C_MAX, C_MAX);
    send_pair(C_MAX, C_MIN, C_MIN, C_MIN);
    // largest differences on both axes, four directions
    send_pair(C_MIN, C_MIN, C_MAX, C_MAX);
    send_pair(C_MAX, C_MAX, C_MIN, C_MIN);
    send_pair(C_MIN, C_MAX, C_MAX, C_MIN);
    send_pair(C_MAX, C_MIN, C_MIN, C_MAX);
    // near the saturation at plus and minus ninety degrees
    send_pair(C_MIN, 0, C_MAX, -1);
    send_pair(C_MAX, 0, C_MIN, 1);
    send_pair(C_MIN, 1, C_MAX, 0);
    // steep vectors with the smallest x step
    send_pair(0, C_MAX, 1, C_MIN);
    send_pair(0, C_MIN, -1, C_MAX);
    // unit diagonals in all four quadrants
    send_pair(0, 0, 1, 1);
    send_pair(0, 0, -1, 1);
    send_pair(0, 0, 1, -1);
    send_pair(0, 0, -1, -1);

    // random part, in phases: normal idling, back to back, long output stall, normal
    repeat (PHASE_LEN) send_random();
    quiet = 1'b1;
    repeat (PHASE_LEN) send_random();
    hold_off = 1'b1;
    repeat (150) send_random();
    quiet = 1'b0;
    repeat (PHASE_LEN - 150) send_random();
    repeat (PHASE_LEN) send_random();

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // let any stray beat show up before the verdict
    repeat (LATENCY + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
